[rtl/core/bdq_pkg.sv]
// bdq_pkg: shared constants, codes and types of the bounded deque
// no dependencies; used by the interfaces, the cell and the top level
package bdq_pkg;

    localparam int DEPTH    = 16;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_REVERSE    = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INS_LOW,
        OP_DEL_LOW,
        OP_INS_HIGH,
        OP_DEL_HIGH
    } t_cell_op;

    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] data;
    } t_link;

endpackage

[rtl/core/bdq_in_if.sv]
// bdq_in_if: command channel of the deque, valid/ready with cmd and value_in
// depends on bdq_pkg
interface bdq_in_if;
    logic                                valid;
    logic                                ready;
    logic [bdq_pkg::CMD_W-1:0]           cmd;
    logic signed [bdq_pkg::DATA_W-1:0]   value_in;

    modport source(output valid, output cmd, output value_in, input ready);
    modport sink(input valid, input cmd, input value_in, output ready);
endinterface

[rtl/core/bdq_out_if.sv]
// bdq_out_if: result channel of the deque, valid/ready with value, status and fill count
// depends on bdq_pkg
interface bdq_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bdq_pkg::DATA_W-1:0]   value_out;
    logic [bdq_pkg::STATUS_W-1:0]        status;
    logic [bdq_pkg::FILL_W-1:0]          fill_count;

    modport source(output valid, output value_out, output status, output fill_count,
                   input ready);
    modport sink(input valid, input value_out, input status, input fill_count,
                 output ready);
endinterface

[rtl/core/bounded_deque_with_reverse.sv]
// bounded_deque_with_reverse: top level, command decode, cell chain and result register
// depends on bdq_pkg, bdq_in_if, bdq_out_if and bdq_cell
//
//   channel  | dir | payload                        | transfer
//   i_req    | in  | cmd, value_in                  | valid & ready
//   o_rsp    | out | value_out, status, fill_count  | valid & ready
//
// one command per cycle while o_rsp takes its results; its result shows in the cycle after the transfer
// values sit in a row of DEPTH cells, packed from cell 0 upward; inserts and removals
// at cell 0 shift the whole row by one cell, those at the top end touch only one cell
// reverse toggles a flag that swaps which end of the row is the logical front
// reset clears all valid bits, the count and the flag at once, no clearing pass
// a stalled result holds in the output register; i_req stalls only while it is full and o_rsp.ready is low
module bounded_deque_with_reverse (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdq_in_if.sink    i_req,
    bdq_out_if.source o_rsp
);

    logic                        r_out_vld;
    logic                        n_out_vld;
    logic [bdq_pkg::DATA_W-1:0]  r_value;
    logic [bdq_pkg::DATA_W-1:0]  n_value;
    bdq_pkg::t_status            r_status;
    bdq_pkg::t_status            n_status;
    logic [bdq_pkg::CNT_W-1:0]   r_count;
    logic [bdq_pkg::CNT_W-1:0]   n_count;
    logic                        r_rev;
    logic                        n_rev;

    logic                        accept;
    logic                        is_full;
    logic                        is_empty;
    bdq_pkg::t_cell_op           cell_op;
    bdq_pkg::t_link              cell_q [bdq_pkg::DEPTH];
    logic [bdq_pkg::DEPTH-1:0]   vld_vec;
    logic [bdq_pkg::DATA_W-1:0]  top_data;

    assign i_req.ready = !r_out_vld || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_full     = (r_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    assign is_empty    = (r_count == '0);

    // cell chain
    for (genvar i = 0; i < bdq_pkg::DEPTH; i++) begin : g_cell
        bdq_pkg::t_link lower;
        bdq_pkg::t_link upper;
        if (i == 0) begin : g_low_end
            assign lower = '{vld: 1'b1, data: i_req.value_in};
        end else begin : g_low_mid
            assign lower = cell_q[i-1];
        end
        if (i == bdq_pkg::DEPTH - 1) begin : g_high_end
            assign upper = '{vld: 1'b0, data: '0};
        end else begin : g_high_mid
            assign upper = cell_q[i+1];
        end
        bdq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (cell_op),
            .i_new   (i_req.value_in),
            .i_lower (lower),
            .i_upper (upper),
            .o_link  (cell_q[i])
        );
        assign vld_vec[i] = cell_q[i].vld;
    end

    // value of the highest occupied cell
    always_comb begin
        top_data = '0;
        for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
            if (vld_vec[i] &&
                (i == bdq_pkg::DEPTH - 1 || !vld_vec[(i + 1) % bdq_pkg::DEPTH])) begin
                top_data = top_data | cell_q[i].data;
            end
        end
    end

    always_comb begin
        cell_op  = bdq_pkg::OP_HOLD;
        n_count  = r_count;
        n_rev    = r_rev;
        n_value  = '0;
        n_status = bdq_pkg::ST_OK;
        if (accept) begin
            unique case (bdq_pkg::t_cmd'(i_req.cmd)) inside
                bdq_pkg::CMD_PUSH_BACK, bdq_pkg::CMD_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = bdq_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + bdq_pkg::CNT_W'(1);
                        if ((i_req.cmd == bdq_pkg::CMD_PUSH_BACK) ^ r_rev) begin
                            cell_op = bdq_pkg::OP_INS_HIGH;
                        end else begin
                            cell_op = bdq_pkg::OP_INS_LOW;
                        end
                    end
                end
                bdq_pkg::CMD_POP_BACK, bdq_pkg::CMD_POP_FRONT: begin
                    if (is_empty) begin
                        n_status = bdq_pkg::ST_EMPTY;
                    end else begin
                        n_count = r_count - bdq_pkg::CNT_W'(1);
                        if ((i_req.cmd == bdq_pkg::CMD_POP_BACK) ^ r_rev) begin
                            cell_op = bdq_pkg::OP_DEL_HIGH;
                            n_value = top_data;
                        end else begin
                            cell_op = bdq_pkg::OP_DEL_LOW;
                            n_value = cell_q[0].data;
                        end
                    end
                end
                bdq_pkg::CMD_REVERSE: begin
                    n_rev = !r_rev;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (accept) begin
            n_out_vld = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_count   <= '0;
            r_rev     <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_count   <= n_count;
            r_rev     <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.value_out  = r_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.fill_count = bdq_pkg::FILL_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
        else $error("count above depth");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(vld_vec) == int'(r_count))
        else $error("cell valid bits disagree with count");

    a_packed_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((vld_vec + bdq_pkg::DEPTH'(1)) & vld_vec) == '0)
        else $error("occupied cells not packed from cell 0");

    a_reverse_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.cmd == bdq_pkg::CMD_REVERSE |=> r_rev != $past(r_rev))
        else $error("reverse did not toggle direction");

endmodule

[rtl/core/bdq_cell.sv]
// bdq_cell: one storage cell of the deque chain, holds a value and its valid bit
// trades data with its lower and upper neighbor; depends on bdq_pkg
module bdq_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bdq_pkg::t_cell_op          i_op,
    input  logic [bdq_pkg::DATA_W-1:0] i_new,
    input  bdq_pkg::t_link             i_lower,
    input  bdq_pkg::t_link             i_upper,
    output bdq_pkg::t_link             o_link
);

    logic                       r_vld;
    logic                       n_vld;
    logic [bdq_pkg::DATA_W-1:0] r_data;
    logic [bdq_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_vld  = r_vld;
        n_data = r_data;
        unique case (i_op)
            bdq_pkg::OP_INS_LOW: begin
                n_vld  = i_lower.vld;
                n_data = i_lower.data;
            end
            bdq_pkg::OP_DEL_LOW: begin
                n_vld  = i_upper.vld;
                n_data = i_upper.data;
            end
            bdq_pkg::OP_INS_HIGH: begin
                if (!r_vld && i_lower.vld) begin
                    n_vld  = 1'b1;
                    n_data = i_new;
                end
            end
            bdq_pkg::OP_DEL_HIGH: begin
                if (r_vld && !i_upper.vld) begin
                    n_vld = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_link.vld  = r_vld;
    assign o_link.data = r_data;

endmodule

[test/bdq_result_checker.sv]
// bdq_result_checker: watches the command and result channels of the deque, keeps its own
// copy of the stored values and the order flag, and compares every result transfer in order
// depends on bdq_pkg, bdq_in_if and bdq_out_if
module bdq_result_checker
    import bdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bdq_in_if    i_req,
    bdq_out_if   i_rsp,
    output int   o_pending,
    output int   o_fail_count
);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
        logic [FILL_W-1:0]        fill;
    } t_deque_result;

    logic signed [DATA_W-1:0] stored_values[$];
    t_deque_result            due_results[$];
    bit                       flipped;
    int                       errs;

    // queue front is the physical low end; the flag swaps which logical end that is
    function automatic t_deque_result apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic signed [DATA_W-1:0] v);
        t_deque_result r;
        r.value  = '0;
        r.status = ST_OK;
        case (cmd) inside
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (stored_values.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else if ((cmd == CMD_PUSH_BACK) != flipped) begin
                    stored_values.push_back(v);
                end else begin
                    stored_values.push_front(v);
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
                if (stored_values.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if ((cmd == CMD_POP_BACK) != flipped) begin
                    r.value = stored_values.pop_back();
                end else begin
                    r.value = stored_values.pop_front();
                end
            end
            CMD_REVERSE: begin
                flipped = !flipped;
            end
            default: begin
            end
        endcase
        r.fill = FILL_W'(stored_values.size());
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_deque_result want;
        if (!i_rst_n) begin
            stored_values.delete();
            due_results.delete();
            flipped = 1'b0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    errs++;
                end else begin
                    want = due_results.pop_front();
                    if (i_rsp.value_out !== want.value) begin
                        $error("value_out: expected %0d, got %0d", want.value, i_rsp.value_out);
                        errs++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_rsp.status);
                        errs++;
                    end
                    if (i_rsp.fill_count !== want.fill) begin
                        $error("fill_count: expected %0d, got %0d", want.fill,
                               i_rsp.fill_count);
                        errs++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                due_results.push_back(apply_command(i_req.cmd, i_req.value_in));
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= errs;
    end

endmodule

[test/bounded_deque_with_reverse_tb.sv]
// bounded_deque_with_reverse_tb: drives commands and result back-pressure into the deque
// and reports the verdict; prediction and comparison live in bdq_result_checker
// depends on bdq_pkg, bdq_in_if, bdq_out_if, bounded_deque_with_reverse and bdq_result_checker
module bounded_deque_with_reverse_tb;
    import bdq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = 3'd5;
    localparam int               RANDOM_ITEMS    = 930;
    localparam int               HOLD_START      = 300;
    localparam int               HOLD_CYCLES     = 120;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   pending;
    int   fail_count;
    bit   no_idle = 1'b0;

    bdq_in_if  req_if ();
    bdq_out_if rsp_if ();

    bounded_deque_with_reverse dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    bdq_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    // valid stays high from one transfer to the next unless a gap is taken
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] v);
        while (!no_idle && $urandom_range(99) < 25) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.cmd      <= cmd;
        req_if.value_in <= v;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd(input int push_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3) return CMD_W'(CMD_UNDEF_FIRST + $urandom_range(2));
        if (roll < 10) return CMD_REVERSE;
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    // receiver: random back-pressure plus one long hold-off
    initial begin : receiver
        int cyc;
        cyc = 0;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= no_idle || ($urandom_range(99) >= 25);
            end
        end
    end

    initial begin : stimulus
        int                       push_pct;
        int                       push_mix[3];
        logic signed [DATA_W-1:0] edge_vals[4];
        logic signed [DATA_W-1:0] v;

        push_mix  = '{85, 15, 50};
        edge_vals = '{32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd0};
        push_pct  = 50;

        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.cmd      <= CMD_PUSH_BACK;
        req_if.value_in <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, reversal, undefined codes
        send_cmd(CMD_POP_BACK, 32'sd77);
        send_cmd(CMD_POP_FRONT, -32'sd5);
        send_cmd(CMD_REVERSE, 32'sd1);
        send_cmd(CMD_REVERSE, 32'sd0);
        send_cmd(CMD_UNDEF_FIRST, 32'sh7fffffff);
        send_cmd(CMD_W'(CMD_UNDEF_FIRST + 1), 32'sh80000000);
        send_cmd(CMD_W'(CMD_UNDEF_FIRST + 2), -32'sd1);
        // extreme values at both ends
        send_cmd(CMD_PUSH_BACK, 32'sh7fffffff);
        send_cmd(CMD_PUSH_FRONT, 32'sh80000000);
        send_cmd(CMD_PUSH_BACK, -32'sd1);
        send_cmd(CMD_PUSH_FRONT, 32'sd0);
        send_cmd(CMD_REVERSE, 32'sd0);
        send_cmd(CMD_PUSH_BACK, 32'sh5a5a5a5a);
        send_cmd(CMD_POP_FRONT, 32'sd9);
        send_cmd(CMD_POP_BACK, 32'sd0);
        send_cmd(CMD_REVERSE, 32'sd0);
        send_cmd(CMD_POP_FRONT, 32'sd0);
        send_cmd(CMD_POP_BACK, 32'sd0);
        send_cmd(CMD_POP_BACK, 32'sd0);
        send_cmd(CMD_POP_FRONT, 32'sd0);
        send_cmd(CMD_POP_FRONT, 32'sd0);

        // bursts biased toward filling, draining or neither
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) push_pct = push_mix[$urandom_range(2)];
            if (n == 500) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            no_idle = (n >= 600 && n < 750);
            v = ($urandom_range(7) == 0) ? edge_vals[$urandom_range(3)] : $urandom();
            send_cmd(pick_cmd(push_pct), v);
        end
        req_if.valid <= 1'b0;
        no_idle = 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[bounded_deque_with_reverse.f]
rtl/core/bdq_pkg.sv
rtl/core/bdq_in_if.sv
rtl/core/bdq_out_if.sv
rtl/core/bdq_cell.sv
rtl/core/bounded_deque_with_reverse.sv
test/bdq_result_checker.sv
test/bounded_deque_with_reverse_tb.sv
